FILE: hw/rtl/f2p_pkg.sv
// Shared types and constants for the float32 to PCM16 converter.
package f2p_pkg;

  // Class of a sample once its exponent has been decoded.
  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_ZERO,
    KIND_SAT,
    KIND_NAN
  } kind_e;

  localparam logic [7:0] ExpMax      = 8'd255;
  // Below this biased exponent the scaled sample is under a quarter.
  localparam logic [7:0] ExpTiny     = 8'd110;
  // From this biased exponent up the scaled sample is beyond full scale.
  localparam logic [7:0] ExpSat      = 8'd128;
  // Right shift that turns the rounded product into integer units is this minus the exponent.
  localparam logic [7:0] ShiftBase   = 8'd150;
  localparam logic [16:0] PosLimit   = 17'd32767;
  localparam logic [16:0] NegLimit   = 17'd32768;
  localparam logic signed [15:0] PcmMax = 16'sd32767;
  localparam logic signed [15:0] PcmMin = -16'sd32768;

  // Product stage: exact mantissa times scale.
  typedef struct packed {
    logic        sign;
    kind_e       kind;
    logic [5:0]  shift;
    logic [38:0] prod;
    logic        last;
  } s1_t;

  // Product rounded to single precision.
  typedef struct packed {
    logic        sign;
    kind_e       kind;
    logic [5:0]  shift;
    logic [39:0] rnd;
    logic        last;
  } s2_t;

  // Integer part with guard and sticky bits.
  typedef struct packed {
    logic        sign;
    kind_e       kind;
    logic [16:0] mag;
    logic        half;
    logic        sticky;
    logic        last;
  } s3_t;

endpackage

FILE: hw/rtl/f2p_fp_mul.sv
// Two pipeline stages: scale the sample by 32767 and round the product to float32.
module f2p_fp_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en1_i,
  input  logic           en2_i,
  input  logic           valid_i,
  input  logic [31:0]    sample_bits_i,
  input  logic           last_i,
  output logic           v1_o,
  output logic           v2_o,
  output f2p_pkg::s2_t   s2_o
);
  import f2p_pkg::*;

  logic        v1_q, v2_q;
  s1_t         s1_d, s1_q;
  s2_t         s2_d, s2_q;
  logic [7:0]  expo;
  logic [22:0] mant;
  logic [38:0] mfull;
  logic [7:0]  shift_w;
  logic [23:0] keep;
  logic        guard, sticky, rup;
  logic [24:0] keep_r;

  // Decode the exponent and form the exact product m * (2^15 - 1).
  always_comb begin
    expo    = sample_bits_i[30:23];
    mant    = sample_bits_i[22:0];
    mfull   = {15'd0, 1'b1, mant};
    shift_w = ShiftBase - expo;
    s1_d.sign  = sample_bits_i[31];
    s1_d.last  = last_i;
    s1_d.shift = shift_w[5:0];
    s1_d.prod  = (mfull << 15) - mfull;
    if (expo == ExpMax) begin
      s1_d.kind = (mant != 23'd0) ? KIND_NAN : KIND_SAT;
    end else if (expo >= ExpSat) begin
      s1_d.kind = KIND_SAT;
    end else if (expo < ExpTiny) begin
      s1_d.kind = KIND_ZERO;
    end else begin
      s1_d.kind = KIND_NORMAL;
    end
  end

  // Round the product to 24 significant bits, ties to even.
  always_comb begin
    if (s1_q.prod[38]) begin
      keep   = s1_q.prod[38:15];
      guard  = s1_q.prod[14];
      sticky = |s1_q.prod[13:0];
    end else begin
      keep   = s1_q.prod[37:14];
      guard  = s1_q.prod[13];
      sticky = |s1_q.prod[12:0];
    end
    rup    = guard & (sticky | keep[0]);
    keep_r = {1'b0, keep} + {24'd0, rup};
    s2_d.sign  = s1_q.sign;
    s2_d.kind  = s1_q.kind;
    s2_d.shift = s1_q.shift;
    s2_d.last  = s1_q.last;
    if (s1_q.prod[38]) begin
      s2_d.rnd = {keep_r, 15'd0};
    end else begin
      s2_d.rnd = {1'b0, keep_r, 14'd0};
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1_i) v1_q <= valid_i;
      if (en2_i) v2_q <= v1_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en1_i) s1_q <= s1_d;
    if (en2_i) s2_q <= s2_d;
  end

  assign v1_o = v1_q;
  assign v2_o = v2_q;
  assign s2_o = s2_q;

endmodule

FILE: hw/rtl/float_to_pcm16_saturate.sv
// Top level of the float32 to saturated 16-bit PCM converter.
// Converts one float32 sample per clock into 16-bit PCM: the sample is scaled by 32767 with
// float32 round-to-nearest-even, clamped to [-32768, 32767] and rounded to the nearest
// integer, ties to even. NaN gives -32768 and infinities saturate; tlast is carried along.
// The pipeline has four register stages (product, float rounding, alignment shift, integer
// rounding and saturation); the edge that accepts a sample loads the first of them, and the
// result is offered on the output from the last. Each stage holds under back-pressure and
// fills bubbles, sustaining one request per cycle while no stage is held.
module float_to_pcm16_saturate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_bits
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] pcm_sample
  output logic        m_axis_tlast
);
  import f2p_pkg::*;

  logic        v1, v2;
  s2_t         s2;
  logic        v3_q, vo_q;
  s3_t         s3_d, s3_q;
  logic [15:0] pcm_d, pcm_q;
  logic        last_q;
  logic        adv_o, adv3, adv2, adv1;
  logic [39:0] shr, shr_h, mask;
  logic [5:0]  sm1;
  logic [16:0] mag_r;

  // Each stage moves when empty or when the one after it moves.
  assign adv_o = !vo_q | m_axis_tready;
  assign adv3  = !v3_q | adv_o;
  assign adv2  = !v2 | adv3;
  assign adv1  = !v1 | adv2;
  assign s_axis_tready = adv1;

  f2p_fp_mul u_mul (
    .clk_i,
    .rst_ni,
    .en1_i         (adv1),
    .en2_i         (adv2),
    .valid_i       (s_axis_tvalid),
    .sample_bits_i (s_axis_tdata),
    .last_i        (s_axis_tlast),
    .v1_o          (v1),
    .v2_o          (v2),
    .s2_o          (s2)
  );

  // Align to integer units and collect the guard and sticky bits.
  always_comb begin
    sm1    = s2.shift - 6'd1;
    shr    = s2.rnd >> s2.shift;
    shr_h  = s2.rnd >> sm1;
    mask   = (40'd1 << sm1) - 40'd1;
    s3_d.sign   = s2.sign;
    s3_d.kind   = s2.kind;
    s3_d.last   = s2.last;
    s3_d.mag    = shr[16:0];
    s3_d.half   = shr_h[0];
    s3_d.sticky = |(s2.rnd & mask);
  end

  // Round to integer and saturate.
  always_comb begin
    mag_r = s3_q.mag + {16'd0, s3_q.half & (s3_q.sticky | s3_q.mag[0])};
    unique case (s3_q.kind)
      KIND_NAN:  pcm_d = PcmMin;
      KIND_SAT:  pcm_d = s3_q.sign ? PcmMin : PcmMax;
      KIND_ZERO: pcm_d = 16'd0;
      default: begin
        if (!s3_q.sign) begin
          pcm_d = (mag_r > PosLimit) ? PcmMax : mag_r[15:0];
        end else begin
          pcm_d = (mag_r > NegLimit) ? PcmMin : (16'd0 - mag_r[15:0]);
        end
      end
    endcase
  end

  // Valid bits of the last two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv3)  v3_q <= v2;
      if (adv_o) vo_q <= v3_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv3) s3_q <= s3_d;
    if (adv_o) begin
      pcm_q  <= pcm_d;
      last_q <= s3_q.last;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = pcm_q;
  assign m_axis_tlast  = last_q;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the float32 to saturated PCM16 converter.
`timescale 1ns / 100ps

module testbench;
  import f2p_pkg::*;

  // Expected output request: PCM value and the frame marker.
  typedef struct {
    logic signed [15:0] pcm;
    logic               last;
  } pcm_req_t;

  // Directed row: sample, marker, typed-in result and whether that result is used.
  typedef struct {
    logic [31:0]        bits;
    logic               last;
    logic signed [15:0] pcm;
    logic               typed;
  } vector_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  pcm_req_t    pcm_expected_q[$];
  pcm_req_t    typed_q[$];
  logic        typed_flag_q[$];
  int          mismatches;
  int          sent_count;
  logic        stimulus_done;
  logic        pressure_done;

  float_to_pcm16_saturate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] sample_bits
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [15:0] pcm_sample
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bit-exact prediction: float32 product with 32767 rounded to nearest even, then
  // rounded to an integer, ties to even, and clamped to the PCM range.
  function automatic logic signed [15:0] predict_pcm(logic [31:0] bits);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] mn;
    logic [23:0] sig;
    logic [39:0] prod;
    logic [39:0] rnd;
    logic [39:0] ip;
    logic        half;
    logic        stk;
    int          msb;
    int          drop;
    int          sh;
    sgn = bits[31];
    ex  = bits[30:23];
    mn  = bits[22:0];
    // NaN gives the negative limit; infinities saturate by sign.
    if (ex == ExpMax) return (mn != 0 || sgn) ? PcmMin : PcmMax;
    // Two or more in magnitude is always beyond full scale.
    if (ex >= ExpSat) return sgn ? PcmMin : PcmMax;
    sig  = (ex == 0) ? {1'b0, mn} : {1'b1, mn};
    prod = 40'(sig) * 40'd32767;
    if (prod == 0) return 16'sd0;
    msb = 0;
    for (int i = 0; i < 40; i++) if (prod[i]) msb = i;
    sh  = (ex == 0) ? 149 : (150 - int'(ex));
    rnd = prod;
    // Round the exact product back to a 24-bit significand.
    if (msb > 23) begin
      drop = msb - 23;
      half = prod[drop-1];
      stk  = |(prod & ((40'd1 << (drop - 1)) - 40'd1));
      rnd  = prod >> drop;
      if (half && (stk || rnd[0])) rnd = rnd + 40'd1;
      sh   = sh - drop;
    end
    // Integer rounding of rnd * 2^-sh, ties to even.
    if (sh > 40) begin
      ip = 40'd0;
    end else begin
      ip   = rnd >> sh;
      half = rnd[sh-1];
      stk  = (sh > 1) ? |(rnd & ((40'd1 << (sh - 1)) - 40'd1)) : 1'b0;
      if (half && (stk || ip[0])) ip = ip + 40'd1;
    end
    if (!sgn) return (ip > 40'd32767) ? PcmMax : $signed(ip[15:0]);
    return (ip > 40'd32768) ? PcmMin : $signed(-ip[15:0]);
  endfunction

  // Mismatch report: one line per failure.
  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Gap length: mostly none, some short, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // Random sample drawn across the interesting classes.
  function automatic logic [31:0] random_sample();
    logic [31:0] b;
    int          r;
    b = $urandom();
    r = $urandom_range(99);
    if (r < 55) begin
      // Audio range, all within plus or minus two.
      b[30:23] = 8'($urandom_range(127, 100));
    end else if (r < 65) begin
      b[30:23] = 8'($urandom_range(128, 126));
    end else if (r < 72) begin
      b[30:23] = ExpMax;
      if ($urandom_range(1)) b[22:0] = '0;
    end else if (r < 78) begin
      b[30:23] = 8'($urandom_range(2));
    end
    return b;
  endfunction

  // Request checking, done at the falling edge where every signal is settled.
  always @(negedge clk_i) begin
    pcm_req_t exp_req;
    pcm_req_t typed_req;
    logic     typed;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        exp_req.pcm  = predict_pcm(s_axis_tdata);
        exp_req.last = s_axis_tlast;
        pcm_expected_q.push_back(exp_req);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pcm_expected_q.size() == 0) begin
          report("unexpected request", $signed(m_axis_tdata), 0);
        end else begin
          exp_req = pcm_expected_q.pop_front();
          if (typed_flag_q.size() > 0) begin
            typed     = typed_flag_q.pop_front();
            typed_req = typed_q.pop_front();
            if (typed) exp_req = typed_req;
          end
          if ($signed(m_axis_tdata) != exp_req.pcm)
            report("pcm_sample", $signed(m_axis_tdata), exp_req.pcm);
          if (m_axis_tlast != exp_req.last)
            report("last_out", m_axis_tlast, exp_req.last);
        end
      end
    end
  end

  // Sender: one request, held until the handshake completes.
  task automatic send_sample(logic [31:0] bits, logic last, int gap);
    logic ok;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bits;
    s_axis_tlast  <= last;
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    sent_count++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stimulus: reset, directed table, then random samples.
  initial begin
    vector_t  vectors[$];
    vector_t  v;
    pcm_req_t t;
    int       gap;
    logic     burst;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    mismatches    = 0;
    sent_count    = 0;
    stimulus_done = 1'b0;
    // Zeros, unit values, infinities, NaNs, largest finite, plus and minus two and subnormals.
    vectors.push_back('{32'h0000_0000, 1'b0, 16'sd0,     1'b1});
    vectors.push_back('{32'h8000_0000, 1'b1, 16'sd0,     1'b1});
    vectors.push_back('{32'h3F80_0000, 1'b0, 16'sd32767, 1'b1});
    vectors.push_back('{32'hBF80_0000, 1'b0, -16'sd32767, 1'b1});
    vectors.push_back('{32'h7F80_0000, 1'b1, PcmMax,     1'b1});
    vectors.push_back('{32'hFF80_0000, 1'b0, PcmMin,     1'b1});
    vectors.push_back('{32'h7FC0_0000, 1'b0, PcmMin,     1'b1});
    vectors.push_back('{32'hFFFF_FFFF, 1'b1, PcmMin,     1'b1});
    vectors.push_back('{32'h7F80_0001, 1'b0, PcmMin,     1'b1});
    vectors.push_back('{32'h7F7F_FFFF, 1'b0, PcmMax,     1'b1});
    vectors.push_back('{32'hFF7F_FFFF, 1'b1, PcmMin,     1'b1});
    vectors.push_back('{32'h4000_0000, 1'b0, PcmMax,     1'b1});
    vectors.push_back('{32'hC000_0000, 1'b0, PcmMin,     1'b1});
    vectors.push_back('{32'h0000_0001, 1'b0, 16'sd0,     1'b1});
    vectors.push_back('{32'h807F_FFFF, 1'b1, 16'sd0,     1'b1});
    // Halves, just below full scale, values near rounding boundaries and two mixed bit patterns.
    vectors.push_back('{32'h3F00_0000, 1'b0, 16'sd0, 1'b0});
    vectors.push_back('{32'hBF00_0000, 1'b0, 16'sd0, 1'b0});
    vectors.push_back('{32'h3F7F_FFFF, 1'b0, 16'sd0, 1'b0});
    vectors.push_back('{32'hBF80_0001, 1'b1, 16'sd0, 1'b0});
    vectors.push_back('{32'h3FFF_FFFF, 1'b0, 16'sd0, 1'b0});
    vectors.push_back('{32'h3820_0000, 1'b0, 16'sd0, 1'b0});
    vectors.push_back('{32'hB8A0_0000, 1'b0, 16'sd0, 1'b0});
    vectors.push_back('{32'h3800_0200, 1'b0, 16'sd0, 1'b0});
    vectors.push_back('{32'h5555_5555, 1'b1, 16'sd0, 1'b0});
    vectors.push_back('{32'hAAAA_AAAA, 1'b0, 16'sd0, 1'b0});
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (vectors[i]) begin
      v = vectors[i];
      t.pcm  = v.pcm;
      t.last = v.last;
      typed_q.push_back(t);
      typed_flag_q.push_back(v.typed);
      send_sample(v.bits, v.last, gap_len());
    end
    // Random part, alternating stretches with and without gaps.
    burst = 1'b0;
    for (int n = 0; n < 1700; n++) begin
      if (n % 200 == 0) burst = ~burst;
      gap = burst ? 0 : gap_len();
      send_sample(random_sample(), 1'($urandom_range(1)), gap);
    end
    s_axis_tvalid <= 1'b0;
    stimulus_done = 1'b1;
    while (pcm_expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  initial begin
    int n;
    m_axis_tready = 1'b0;
    pressure_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!pressure_done && sent_count >= 600) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        pressure_done = 1'b1;
      end
      n = stimulus_done ? 0 : gap_len();
      if (n == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/f2p_pkg.sv
hw/rtl/f2p_fp_mul.sv
hw/rtl/float_to_pcm16_saturate.sv
sim/testbench.sv
